[sv/crd_pkg.sv]
// Shared types and constants for the camera row deframer.
`default_nettype none

package crd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADDR_W = 10;

  localparam logic [BYTE_W-1:0] START_CHAR = 8'h59;
  localparam logic [BYTE_W-1:0] SEP_CHAR   = 8'h3A;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_SEP,
    ST_ROWNUM,
    ST_PIXEL,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic latch_row;
    logic wr_pixel;
    logic rd_pixel;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_sep;
    logic wcol_last;
    logic rcol_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[sv/crd_ctrl.sv]
// Framing controller that tracks the row header and sequences the row flush.
`default_nettype none

module crd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire crd_pkg::sts_t sts_i,
  output crd_pkg::cmd_t      cmd_o
);

  crd_pkg::state_e state_q;
  crd_pkg::state_e state_d;
  logic            accept;

  assign in_stall_o = (state_q == crd_pkg::ST_FLUSH);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crd_pkg::ST_HUNT: begin
        if (accept && sts_i.is_start) state_d = crd_pkg::ST_SEP;
      end
      crd_pkg::ST_SEP: begin
        if (accept) state_d = sts_i.is_sep ? crd_pkg::ST_ROWNUM : crd_pkg::ST_HUNT;
      end
      crd_pkg::ST_ROWNUM: begin
        if (accept) state_d = crd_pkg::ST_PIXEL;
      end
      crd_pkg::ST_PIXEL: begin
        if (accept && sts_i.wcol_last) state_d = crd_pkg::ST_FLUSH;
      end
      crd_pkg::ST_FLUSH: begin
        if (sts_i.out_free && sts_i.rcol_last) state_d = crd_pkg::ST_HUNT;
      end
      default: begin
        state_d = crd_pkg::ST_HUNT;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      crd_pkg::ST_ROWNUM: begin
        cmd_o.latch_row = accept;
      end
      crd_pkg::ST_PIXEL: begin
        cmd_o.wr_pixel = accept;
      end
      crd_pkg::ST_FLUSH: begin
        cmd_o.rd_pixel = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crd_pkg::ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/crd_datapath.sv]
// Datapath with the row store, column counters, row base address and output register.
`default_nettype none

module crd_datapath #(
  parameter int unsigned ROW_BYTES = 16,
  parameter int unsigned ROWS      = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [crd_pkg::BYTE_W-1:0]   rx_byte_i,
  input  wire crd_pkg::cmd_t                cmd_i,
  output crd_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [crd_pkg::ADDR_W-1:0]        pixel_address_o,
  output logic [crd_pkg::BYTE_W-1:0]        pixel_byte_o,
  output logic                              row_done_o
);

  localparam int unsigned ColW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam logic [ColW-1:0] ColLast = ColW'(ROW_BYTES - 1);
  localparam int unsigned ProdW = crd_pkg::BYTE_W + 8;

  logic [crd_pkg::BYTE_W-1:0] row_mem [ROW_BYTES];

  logic [ColW-1:0]            wcol_q;
  logic [ColW-1:0]            wcol_d;
  logic [ColW-1:0]            rcol_q;
  logic [ColW-1:0]            rcol_d;
  logic [crd_pkg::ADDR_W-1:0] base_q;
  logic [crd_pkg::ADDR_W-1:0] base_d;
  logic [ProdW-1:0]           row_prod;
  logic                       out_valid_q;
  logic                       out_valid_d;
  logic [crd_pkg::ADDR_W-1:0] addr_q;
  logic [crd_pkg::BYTE_W-1:0] byte_q;
  logic                       last_q;

  assign sts_o.is_start  = (rx_byte_i == crd_pkg::START_CHAR);
  assign sts_o.is_sep    = (rx_byte_i == crd_pkg::SEP_CHAR);
  assign sts_o.wcol_last = (wcol_q == ColLast);
  assign sts_o.rcol_last = (rcol_q == ColLast);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // Row numbers past the frame height fold onto the first row.
  assign row_prod = ProdW'(rx_byte_i) * ProdW'(ROW_BYTES);

  always_comb begin
    base_d = base_q;
    if (cmd_i.latch_row) begin
      if (32'(rx_byte_i) >= ROWS) begin
        base_d = '0;
      end else begin
        base_d = row_prod[crd_pkg::ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    wcol_d = wcol_q;
    if (cmd_i.wr_pixel) begin
      wcol_d = sts_o.wcol_last ? '0 : wcol_q + 1'b1;
    end
    rcol_d = rcol_q;
    if (cmd_i.rd_pixel) begin
      rcol_d = sts_o.rcol_last ? '0 : rcol_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.rd_pixel) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcol_q      <= '0;
      rcol_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wcol_q      <= wcol_d;
      rcol_q      <= rcol_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    if (cmd_i.wr_pixel) begin
      row_mem[wcol_q] <= rx_byte_i;
    end
    if (cmd_i.rd_pixel) begin
      byte_q <= row_mem[rcol_q];
      addr_q <= base_q + crd_pkg::ADDR_W'(rcol_q);
      last_q <= sts_o.rcol_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = addr_q;
  assign pixel_byte_o    = byte_q;
  assign row_done_o      = last_q;

endmodule

`default_nettype wire

[sv/camera_row_deframer_top.sv]
// Top level of the camera row deframer.
// The input channel takes one received byte per word. A row frame is the start
// byte 'Y', the separator ':', a row number byte and ROW_BYTES pixel bytes.
// Bytes that do not fit the header are dropped and framing starts over.
// The output channel gives one word per stored pixel byte, in column order, with
// its frame-buffer address (row times ROW_BYTES plus column, ten bits) and a flag
// on the last byte of the row. Row numbers of ROWS or more address row zero.
// The input is not stalled for header or pixel bytes; it stalls only during a flush.
// After the last pixel byte is accepted, the controller enters the flush state and
// the row is read into the output register and leaves at one word per cycle when
// the receiver does not stall. The row store has a single read port, which sets
// that one-word-per-cycle flush rate.
// While the row is flushed, in_stall_o stays high; it drops in the cycle after
// the last word is loaded into the output register, so the next frame may start
// while that word still waits. A receiver stall holds the output word and pauses
// the flush. Reset returns framing to the start-byte search and empties the
// output register; the row store keeps no reset value.
`default_nettype none

module camera_row_deframer_top #(
  parameter int unsigned ROW_BYTES = 16,
  parameter int unsigned ROWS      = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [crd_pkg::BYTE_W-1:0]   rx_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [crd_pkg::ADDR_W-1:0]        pixel_address_o,
  output logic [crd_pkg::BYTE_W-1:0]        pixel_byte_o,
  output logic                              row_done_o
);

  crd_pkg::cmd_t cmd;
  crd_pkg::sts_t sts;

  crd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crd_datapath #(
    .ROW_BYTES (ROW_BYTES),
    .ROWS      (ROWS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_address_o (pixel_address_o),
    .pixel_byte_o    (pixel_byte_o),
    .row_done_o      (row_done_o)
  );

`ifndef SYNTHESIS
  a_flush_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_pixel && sts.wcol_last |=> in_stall_o)
    else $error("flush did not start after the last pixel byte");

  a_flush_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_pixel && sts.rcol_last |=> !in_stall_o && out_valid_o && row_done_o)
    else $error("flush did not end with a row_done word");

  a_no_write_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !cmd.wr_pixel && !cmd.latch_row)
    else $error("row store or row number changed during a flush");

  a_read_only_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_pixel |-> in_stall_o && (!out_valid_o || !out_stall_i))
    else $error("row store read outside a flush or into a held word");
`endif

endmodule

`default_nettype wire

[tb/sv/camera_row_deframer_top_test.sv]
// Self-checking testbench for the camera row deframer top level.
`timescale 1ns / 1ps

module camera_row_deframer_top_test;

  localparam int unsigned ROW_BYTES    = 16;
  localparam int unsigned ROWS         = 64;
  localparam int unsigned HEADER_BYTES = 3;
  localparam int unsigned FRAME_LEN    = HEADER_BYTES + ROW_BYTES;

  typedef struct packed {
    logic [crd_pkg::ADDR_W-1:0] addr;
    logic [crd_pkg::BYTE_W-1:0] pixels;
    logic                       last;
  } pixel_word_t;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic [crd_pkg::BYTE_W-1:0] rx_byte   = '0;
  logic                       out_stall = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic [crd_pkg::ADDR_W-1:0] pixel_address;
  logic [crd_pkg::BYTE_W-1:0] pixel_byte;
  logic                       row_done;

  logic [crd_pkg::BYTE_W-1:0] rx_script [$];
  pixel_word_t                pixel_expect [$];
  pixel_word_t                head_word;

  int unsigned                frame_pos = 0;
  logic [crd_pkg::BYTE_W-1:0] row_latch = '0;
  logic [crd_pkg::BYTE_W-1:0] row_buf [ROW_BYTES];

  int                         err_cnt       = 0;
  int                         bytes_sent    = 0;
  int                         words_checked = 0;
  int                         hold_left     = 0;
  logic                       hold_done     = 1'b0;

  camera_row_deframer_top #(
    .ROW_BYTES(ROW_BYTES),
    .ROWS     (ROWS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_address_o(pixel_address),
    .pixel_byte_o   (pixel_byte),
    .row_done_o     (row_done)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    err_cnt++;
  endtask

  task automatic absorb_rx_byte(input logic [crd_pkg::BYTE_W-1:0] b);
    int unsigned base;
    pixel_word_t w;
    if (frame_pos == 0) begin
      if (b == crd_pkg::START_CHAR) frame_pos = 1;
    end else if (frame_pos == 1) begin
      frame_pos = (b == crd_pkg::SEP_CHAR) ? 2 : 0;
    end else if (frame_pos == 2) begin
      row_latch = b;
      frame_pos = 3;
    end else begin
      row_buf[frame_pos - HEADER_BYTES] = b;
      frame_pos++;
      if (frame_pos == FRAME_LEN) begin
        frame_pos = 0;
        base = (row_latch >= ROWS) ? 0 : row_latch * ROW_BYTES;
        for (int k = 0; k < ROW_BYTES; k++) begin
          w.addr   = crd_pkg::ADDR_W'(base + k);
          w.pixels = row_buf[k];
          w.last   = (k == ROW_BYTES - 1);
          pixel_expect.push_back(w);
        end
      end
    end
  endtask

  function automatic logic [crd_pkg::BYTE_W-1:0] random_pixel();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return crd_pkg::START_CHAR;
    if (pick == 1) return crd_pkg::SEP_CHAR;
    return crd_pkg::BYTE_W'($urandom_range(255));
  endfunction

  function automatic logic [crd_pkg::BYTE_W-1:0] random_row();
    case ($urandom_range(3))
      0, 1: return crd_pkg::BYTE_W'($urandom_range(ROWS - 1));
      2: return crd_pkg::BYTE_W'($urandom_range(255, ROWS));
      default: begin
        case ($urandom_range(3))
          0: return 8'd0;
          1: return crd_pkg::BYTE_W'(ROWS - 1);
          2: return crd_pkg::BYTE_W'(ROWS);
          default: return 8'hFF;
        endcase
      end
    endcase
  endfunction

  task automatic queue_frame(input logic [crd_pkg::BYTE_W-1:0] row, input int n_pix);
    rx_script.push_back(crd_pkg::START_CHAR);
    rx_script.push_back(crd_pkg::SEP_CHAR);
    rx_script.push_back(row);
    for (int k = 0; k < n_pix; k++) rx_script.push_back(random_pixel());
  endtask

  initial begin
    logic [crd_pkg::BYTE_W-1:0] edge_pixels [ROW_BYTES];
    logic [crd_pkg::BYTE_W-1:0] b;
    int                         frame_bytes;
    int                         pick;
    edge_pixels = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55,
                    crd_pkg::START_CHAR, crd_pkg::SEP_CHAR,
                    8'h7F, 8'hFE, 8'h0F, 8'hF0, 8'h00, 8'hFF,
                    crd_pkg::START_CHAR, crd_pkg::SEP_CHAR};
    // Framing errors: bad start bytes, a repeated start byte and a bad separator.
    rx_script = '{8'h00, 8'hFF, crd_pkg::SEP_CHAR, crd_pkg::START_CHAR,
                  crd_pkg::START_CHAR, crd_pkg::SEP_CHAR, crd_pkg::START_CHAR, 8'h00};
    rx_script.push_back(crd_pkg::START_CHAR);
    rx_script.push_back(crd_pkg::SEP_CHAR);
    rx_script.push_back(crd_pkg::BYTE_W'(ROWS - 1));
    foreach (edge_pixels[k]) rx_script.push_back(edge_pixels[k]);
    rx_script.push_back(crd_pkg::START_CHAR);
    rx_script.push_back(crd_pkg::SEP_CHAR);
    rx_script.push_back(crd_pkg::BYTE_W'(ROWS));
    foreach (edge_pixels[k]) rx_script.push_back(~edge_pixels[k]);

    frame_bytes = 0;
    while (frame_bytes < 150) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        queue_frame(random_row(), ROW_BYTES);
        frame_bytes += FRAME_LEN;
      end else if (pick < 85) begin
        repeat ($urandom_range(4, 1))
          rx_script.push_back(crd_pkg::BYTE_W'($urandom_range(255)));
      end else if (pick < 93) begin
        rx_script.push_back(crd_pkg::START_CHAR);
        if ($urandom_range(1) == 0) begin
          b = crd_pkg::START_CHAR;
        end else begin
          do b = crd_pkg::BYTE_W'($urandom_range(255)); while (b == crd_pkg::SEP_CHAR);
        end
        rx_script.push_back(b);
      end else begin
        pick = $urandom_range(ROW_BYTES - 1);
        queue_frame(random_row(), pick);
        frame_bytes += HEADER_BYTES + pick;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (rx_script.size() != 0 || in_valid || pixel_expect.size() != 0);
    repeat (2 * ROW_BYTES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      rx_byte  <= '0;
    end else begin
      if (in_valid && !in_stall) absorb_rx_byte(rx_byte);
      if (!in_valid || !in_stall) begin
        if (rx_script.size() != 0 &&
            ((bytes_sent >= 120 && bytes_sent < 220) || $urandom_range(99) >= 20)) begin
          in_valid   <= 1'b1;
          rx_byte    <= rx_script.pop_front();
          bytes_sent <= bytes_sent + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && words_checked >= 40) begin
      // Long back-pressure so the row store fills and the input side stalls.
      hold_left <= 300;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (words_checked >= 100 && words_checked < 180) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected word addr=%0d byte=%02h last=%0b",
                                  pixel_address, pixel_byte, row_done));
      end else begin
        head_word = pixel_expect.pop_front();
        if (pixel_address !== head_word.addr)
          report_mismatch($sformatf("pixel_address %0d, expected %0d",
                                    pixel_address, head_word.addr));
        if (pixel_byte !== head_word.pixels)
          report_mismatch($sformatf("pixel_byte %02h, expected %02h at addr %0d",
                                    pixel_byte, head_word.pixels, head_word.addr));
        if (row_done !== head_word.last)
          report_mismatch($sformatf("row_done %0b, expected %0b at addr %0d",
                                    row_done, head_word.last, head_word.addr));
      end
      words_checked <= words_checked + 1;
    end
  end

endmodule

[files.f]
sv/crd_pkg.sv
sv/crd_ctrl.sv
sv/crd_datapath.sv
sv/camera_row_deframer_top.sv
tb/sv/camera_row_deframer_top_test.sv
